// ===== rtl/wffs_pkg.sv =====
// ----------------------------------------------------------------------------
// wffs_pkg: shared types and codes of the window flood fill segmenter
// Command kinds, sequencer states, register indexes and image limits.
// ----------------------------------------------------------------------------
package wffs_pkg;

   // image and window limits; the 8-bit coordinate ports fix the image ones
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_WINDOW = 15;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_CLEAR = 2'd1,
      KIND_FILL  = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SEED_RD,
      ST_SEED_CHK,
      ST_POP,
      ST_POP_WAIT,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_SCAN_CHK,
      ST_READ_WAIT,
      ST_READ_CHK,
      ST_DONE
   } state_type;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_WINDOW = 2'd2;
   localparam logic [1:0] REG_COLOR  = 2'd3;

   localparam int MARK_W  = 17;
   localparam int COUNT_W = 17;

   typedef struct packed {
      logic [8:0] image_width;
      logic [8:0] image_height;
      logic [3:0] window_size;
      logic [7:0] valid_color;
   } cfg_type;

endpackage

// ===== rtl/wffs_csr.sv =====
// ----------------------------------------------------------------------------
// wffs_csr: configuration registers
// APB-style register file for width, height, window and valid color.
// ----------------------------------------------------------------------------
module wffs_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output wffs_pkg::cfg_type    cfg
);
   wffs_pkg::cfg_type cfg_ff;
   logic              wr;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= 9'd256;
         cfg_ff.image_height <= 9'd256;
         cfg_ff.window_size  <= 4'd3;
         cfg_ff.valid_color  <= 8'd0;
      end else if (wr) begin
         case (paddr[3:2])
            wffs_pkg::REG_WIDTH:  cfg_ff.image_width  <= pwdata[8:0];
            wffs_pkg::REG_HEIGHT: cfg_ff.image_height <= pwdata[8:0];
            wffs_pkg::REG_WINDOW: cfg_ff.window_size  <= pwdata[3:0];
            wffs_pkg::REG_COLOR:  cfg_ff.valid_color  <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = 32'd0;
      case (paddr[3:2])
         wffs_pkg::REG_WIDTH:  prdata = {23'd0, cfg_ff.image_width};
         wffs_pkg::REG_HEIGHT: prdata = {23'd0, cfg_ff.image_height};
         wffs_pkg::REG_WINDOW: prdata = {28'd0, cfg_ff.window_size};
         wffs_pkg::REG_COLOR:  prdata = {24'd0, cfg_ff.valid_color};
         default: prdata = 32'd0;
      endcase
   end
endmodule

// ===== rtl/window_flood_fill_segment_top.sv =====
// ----------------------------------------------------------------------------
// window_flood_fill_segment_top: window flood fill segmenter
// Image and mark memories with a sequencer that walks a breadth-first queue.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake
//  ----------+-----------+---------------------------------------------
//  req_      | in        | transfer when start high and busy low
//  rsp_      | out       | one-cycle strobe, receiver cannot stall
//  csr_      | in/out    | APB-style, pready always high
//
// A write strobes its result through DONE; a read goes through READ_WAIT,
// READ_CHK and DONE. Clear sweeps the mark memory one entry a cycle over
// all MAX_WIDTH*MAX_HEIGHT entries, then strobes through DONE. A fill checks
// the seed in SEED_RD and SEED_CHK, pops each member through POP and
// POP_WAIT, and visits each window position through SCAN, SCAN_WAIT and
// SCAN_CHK inside the image (SCAN and SCAN_CHK outside), set by the
// single-port mark memory. Reset clears control state only; the mark memory
// is cleared by a pass over every entry after reset, during which busy stays
// high. A new transfer may be taken in the strobe cycle. No receiver stalls.
// ----------------------------------------------------------------------------
module window_flood_fill_segment_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_pos_x,
   input  logic [7:0]  req_pos_y,
   input  logic [7:0]  req_pixel_value,
   output logic        rsp_strobe,
   output logic        rsp_status,
   output logic [7:0]  rsp_box_x_min,
   output logic [7:0]  rsp_box_y_min,
   output logic [8:0]  rsp_box_width,
   output logic [8:0]  rsp_box_height,
   output logic [16:0] rsp_member_count,
   output logic [7:0]  rsp_read_value,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int XW    = $clog2(wffs_pkg::MAX_WIDTH);
   localparam int YW    = $clog2(wffs_pkg::MAX_HEIGHT);
   localparam int AW    = XW + YW;
   localparam int NPIX  = wffs_pkg::MAX_WIDTH * wffs_pkg::MAX_HEIGHT;
   localparam int QW    = AW + 1;
   localparam int DW    = 14; // wide enough for signed coordinates

   wffs_pkg::cfg_type cfg;

   wffs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // memories: image and mark one port each, queue one write and one read
   // port; all reads registered
   logic [7:0]                      image_mem [NPIX];
   logic [wffs_pkg::MARK_W-1:0]     mark_mem  [NPIX];
   logic [AW-1:0]                   queue_mem [NPIX];

   logic                            img_we, mark_we, q_we;
   logic [AW-1:0]                   img_addr, mark_addr;
   logic [AW-1:0]                   q_waddr, q_raddr;
   logic [7:0]                      img_wdata, img_rd_ff;
   logic [wffs_pkg::MARK_W-1:0]     mark_wdata, mark_rd_ff;
   logic [AW-1:0]                   q_rd_ff;
   logic [AW-1:0]                   q_wdata_c;

   // control and working registers
   wffs_pkg::state_type         state_ff, state_in;
   logic [AW:0]                 clr_ff, clr_in;
   logic [1:0]                  kind_ff, kind_in;
   logic [7:0]                  px_ff, px_in, py_ff, py_in;
   logic [wffs_pkg::MARK_W-1:0] num_ff, num_in;
   logic [QW-1:0]               head_ff, head_in, tail_ff, tail_in;
   logic [XW-1:0]               cx_ff, cx_in;
   logic [YW-1:0]               cy_ff, cy_in;
   logic signed [DW-1:0]        dx_ff, dx_in, dy_ff, dy_in;
   logic [XW-1:0]               nx_ff, nx_in;
   logic [YW-1:0]               ny_ff, ny_in;
   logic [XW-1:0]               xmin_ff, xmin_in, xmax_ff, xmax_in;
   logic [YW-1:0]               ymin_ff, ymin_in, ymax_ff, ymax_in;
   logic [7:0]                  bx_ff, bx_in, by_ff, by_in;
   logic [8:0]                  bw_ff, bw_in, bh_ff, bh_in;
   logic [16:0]                 cnt_ff, cnt_in;
   logic                        stat_ff, stat_in;
   logic [7:0]                  rd_ff, rd_in;
   logic                        strobe_ff, strobe_in;
   logic                        busy_cmd_ff;

   // clamped dimensions and reach
   logic [12:0] w_c, h_c;
   logic [4:0]  ws_c;
   logic signed [DW-1:0] reach_c;
   logic signed [DW-1:0] sx_c, sy_c;
   logic        accept;
   logic [8:0]  ox_c, oy_c;
   logic [9:0]  rx_c, ry_c;

   always_ff @(posedge clock) begin
      if (img_we) image_mem[img_addr] <= img_wdata;
      img_rd_ff <= image_mem[img_addr];
   end
   always_ff @(posedge clock) begin
      if (mark_we) mark_mem[mark_addr] <= mark_wdata;
      mark_rd_ff <= mark_mem[mark_addr];
   end
   always_ff @(posedge clock) begin
      if (q_we) queue_mem[q_waddr] <= q_wdata_c;
      q_rd_ff <= queue_mem[q_raddr];
   end

   always_comb begin
      w_c = (cfg.image_width == 9'd0) ? 13'd1 :
            ({4'd0, cfg.image_width} > 13'(wffs_pkg::MAX_WIDTH)) ? 13'(wffs_pkg::MAX_WIDTH)
            : {4'd0, cfg.image_width};
      h_c = (cfg.image_height == 9'd0) ? 13'd1 :
            ({4'd0, cfg.image_height} > 13'(wffs_pkg::MAX_HEIGHT)) ? 13'(wffs_pkg::MAX_HEIGHT)
            : {4'd0, cfg.image_height};
      ws_c = ({1'b0, cfg.window_size} > 5'(wffs_pkg::MAX_WINDOW)) ? 5'(wffs_pkg::MAX_WINDOW)
             : {1'b0, cfg.window_size};
      reach_c = DW'(ws_c >> 1);
      // shared adder: one neighbour coordinate for each window position
      sx_c = DW'(cx_ff) + dx_ff;
      sy_c = DW'(cy_ff) + dy_ff;
   end

   assign accept = start && !busy;
   assign busy   = (state_ff != wffs_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= wffs_pkg::ST_CLEAR;
         clr_ff    <= '0;
         num_ff    <= '0;
         bx_ff     <= '0;
         by_ff     <= '0;
         bw_ff     <= '0;
         bh_ff     <= '0;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         num_ff    <= num_in;
         bx_ff     <= bx_in;
         by_ff     <= by_in;
         bw_ff     <= bw_in;
         bh_ff     <= bh_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      head_ff <= head_in;
      tail_ff <= tail_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      nx_ff   <= nx_in;
      ny_ff   <= ny_in;
      xmin_ff <= xmin_in;
      xmax_ff <= xmax_in;
      ymin_ff <= ymin_in;
      ymax_ff <= ymax_in;
      stat_ff <= stat_in;
      rd_ff   <= rd_in;
   end

   assign ox_c = {1'b0, px_ff};
   assign oy_c = {1'b0, py_ff};
   assign rx_c = {2'b0, bx_ff} + {1'b0, ox_c};
   assign ry_c = {2'b0, by_ff} + {1'b0, oy_c};

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      kind_in  = kind_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      num_in   = num_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      nx_in    = nx_ff;
      ny_in    = ny_ff;
      xmin_in  = xmin_ff;
      xmax_in  = xmax_ff;
      ymin_in  = ymin_ff;
      ymax_in  = ymax_ff;
      bx_in    = bx_ff;
      by_in    = by_ff;
      bw_in    = bw_ff;
      bh_in    = bh_ff;
      cnt_in   = cnt_ff;
      stat_in  = stat_ff;
      rd_in    = rd_ff;
      strobe_in = 1'b0;
      img_we    = 1'b0;
      img_addr  = {py_ff[YW-1:0], px_ff[XW-1:0]};
      img_wdata = req_pixel_value;
      mark_we   = 1'b0;
      mark_addr = {py_ff[YW-1:0], px_ff[XW-1:0]};
      mark_wdata = num_ff;
      q_we      = 1'b0;
      q_waddr   = tail_ff[AW-1:0];
      q_wdata_c = {ny_ff, nx_ff};
      q_raddr   = head_ff[AW-1:0];

      case (state_ff)
         wffs_pkg::ST_IDLE: begin
            if (accept) begin
               kind_in = req_kind;
               px_in   = req_pos_x;
               py_in   = req_pos_y;
               stat_in = 1'b0;
               rd_in   = 8'd0;
               case (wffs_pkg::kind_type'(req_kind))
                  wffs_pkg::KIND_WRITE: begin
                     // drop writes outside the image in use
                     img_addr = {req_pos_y[YW-1:0], req_pos_x[XW-1:0]};
                     if ({5'd0, req_pos_x} < w_c && {5'd0, req_pos_y} < h_c)
                        img_we = 1'b1;
                     state_in = wffs_pkg::ST_DONE;
                  end
                  wffs_pkg::KIND_CLEAR: begin
                     clr_in   = '0;
                     state_in = wffs_pkg::ST_CLEAR;
                  end
                  wffs_pkg::KIND_FILL: begin
                     if ({5'd0, req_pos_x} >= w_c || {5'd0, req_pos_y} >= h_c) begin
                        stat_in  = 1'b1;
                        state_in = wffs_pkg::ST_DONE;
                     end else begin
                        state_in = wffs_pkg::ST_SEED_RD;
                     end
                  end
                  default: state_in = wffs_pkg::ST_READ_WAIT;
               endcase
            end
         end
         wffs_pkg::ST_CLEAR: begin
            // sweep the mark memory one entry a cycle
            mark_we    = 1'b1;
            mark_addr  = clr_ff[AW-1:0];
            mark_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(NPIX - 1))
               state_in = (kind_ff == wffs_pkg::KIND_CLEAR && busy_cmd_ff)
                          ? wffs_pkg::ST_DONE : wffs_pkg::ST_IDLE;
         end
         wffs_pkg::ST_SEED_RD: begin
            state_in = wffs_pkg::ST_SEED_CHK;
         end
         wffs_pkg::ST_SEED_CHK: begin
            if (mark_rd_ff != '0) begin
               stat_in  = 1'b1;
               state_in = wffs_pkg::ST_DONE;
            end else begin
               num_in = (num_ff == {wffs_pkg::MARK_W{1'b1}}) ? 17'd1
                        : num_ff + 1'b1;
               mark_we    = 1'b1;
               mark_wdata = (num_ff == {wffs_pkg::MARK_W{1'b1}}) ? 17'd1
                            : num_ff + 1'b1;
               q_we      = 1'b1;
               q_waddr   = '0;
               q_wdata_c = {py_ff[YW-1:0], px_ff[XW-1:0]};
               head_in   = '0;
               tail_in   = QW'(1);
               xmin_in   = px_ff[XW-1:0];
               xmax_in   = px_ff[XW-1:0];
               ymin_in   = py_ff[YW-1:0];
               ymax_in   = py_ff[YW-1:0];
               state_in  = wffs_pkg::ST_POP;
            end
         end
         wffs_pkg::ST_POP: begin
            if (head_ff == tail_ff) begin
               bx_in  = 8'(xmin_ff);
               by_in  = 8'(ymin_ff);
               bw_in  = 9'({1'b0, xmax_ff} - {1'b0, xmin_ff} + 1'b1);
               bh_in  = 9'({1'b0, ymax_ff} - {1'b0, ymin_ff} + 1'b1);
               cnt_in = (tail_ff > QW'(17'h1FFFF)) ? 17'h1FFFF : 17'(tail_ff);
               state_in = wffs_pkg::ST_DONE;
            end else begin
               state_in = wffs_pkg::ST_POP_WAIT;
            end
         end
         wffs_pkg::ST_POP_WAIT: begin
            cx_in    = q_rd_ff[XW-1:0];
            cy_in    = q_rd_ff[AW-1:XW];
            head_in  = head_ff + 1'b1;
            dx_in    = -reach_c;
            dy_in    = -reach_c;
            state_in = wffs_pkg::ST_SCAN;
         end
         wffs_pkg::ST_SCAN: begin
            // one window position a pass through the shared adder
            nx_in = sx_c[XW-1:0];
            ny_in = sy_c[YW-1:0];
            if (sx_c < 0 || sx_c >= DW'(w_c) || sy_c < 0 || sy_c >= DW'(h_c)) begin
               state_in = wffs_pkg::ST_SCAN_CHK;
               stat_in  = 1'b1; // skip flag
            end else begin
               stat_in  = 1'b0;
               state_in = wffs_pkg::ST_SCAN_WAIT;
            end
            mark_addr = {sy_c[YW-1:0], sx_c[XW-1:0]};
            img_addr  = {sy_c[YW-1:0], sx_c[XW-1:0]};
         end
         wffs_pkg::ST_SCAN_WAIT: begin
            // hold the neighbour address so the read data stays put
            mark_addr = {ny_ff, nx_ff};
            img_addr  = {ny_ff, nx_ff};
            state_in  = wffs_pkg::ST_SCAN_CHK;
         end
         wffs_pkg::ST_SCAN_CHK: begin
            mark_addr = {ny_ff, nx_ff};
            if (!stat_ff && mark_rd_ff == '0 && img_rd_ff == cfg.valid_color) begin
               mark_we = 1'b1;
               if (tail_ff < QW'(NPIX)) begin
                  q_we    = 1'b1;
                  tail_in = tail_ff + 1'b1;
               end
               if (nx_ff < xmin_ff) xmin_in = nx_ff;
               if (nx_ff > xmax_ff) xmax_in = nx_ff;
               if (ny_ff < ymin_ff) ymin_in = ny_ff;
               if (ny_ff > ymax_ff) ymax_in = ny_ff;
            end
            stat_in = 1'b0;
            if (dx_ff == reach_c) begin
               dx_in = -reach_c;
               if (dy_ff == reach_c) state_in = wffs_pkg::ST_POP;
               else begin
                  dy_in    = dy_ff + 1'b1;
                  state_in = wffs_pkg::ST_SCAN;
               end
            end else begin
               dx_in    = dx_ff + 1'b1;
               state_in = wffs_pkg::ST_SCAN;
            end
         end
         wffs_pkg::ST_READ_WAIT: begin
            mark_addr = {ry_c[YW-1:0], rx_c[XW-1:0]};
            img_addr  = {ry_c[YW-1:0], rx_c[XW-1:0]};
            state_in  = wffs_pkg::ST_READ_CHK;
         end
         wffs_pkg::ST_READ_CHK: begin
            if (bw_ff == 9'd0 || bh_ff == 9'd0 || ox_c >= bw_ff || oy_c >= bh_ff
                || rx_c >= 10'(wffs_pkg::MAX_WIDTH) || ry_c >= 10'(wffs_pkg::MAX_HEIGHT)
                || mark_rd_ff != num_ff)
               rd_in = 8'd255;
            else if (cfg.valid_color == 8'd255)
               rd_in = 8'd0;
            else
               rd_in = img_rd_ff;
            state_in = wffs_pkg::ST_DONE;
         end
         wffs_pkg::ST_DONE: begin
            strobe_in = 1'b1;
            state_in  = wffs_pkg::ST_IDLE;
         end
         default: state_in = wffs_pkg::ST_IDLE;
      endcase
   end

   // a clear command answers; the clearing pass after reset does not
   always_ff @(posedge clock) begin
      if (reset) busy_cmd_ff <= 1'b0;
      else if (accept) busy_cmd_ff <= 1'b1;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = strobe_ff ? stat_ff : 1'b0;
   assign rsp_box_x_min    = bx_ff;
   assign rsp_box_y_min    = by_ff;
   assign rsp_box_width    = bw_ff;
   assign rsp_box_height   = bh_ff;
   assign rsp_member_count = cnt_ff;
   assign rsp_read_value   = rd_ff;

   // result strobe only follows a completed command
   a_strobe_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == wffs_pkg::ST_DONE))
      else $error("strobe without completion");
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wffs_pkg::ST_IDLE && !start) |=> (state_ff == wffs_pkg::ST_IDLE))
      else $error("sequencer left idle without a transfer");
   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wffs_pkg::ST_POP) |-> (head_ff <= tail_ff))
      else $error("queue head passed tail");
endmodule
